FILE: rtl/wtcw_pkg.sv
// Shared types, widths and constants for the wrapped text cell writer.
`timescale 1ns / 1ps

package wtcw_pkg;

   // field widths
   localparam int COL_W      = 7;
   localparam int ROW_W      = 5;
   localparam int CHAR_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   // widths for screen position sums (origin + cursor + tab step)
   localparam int SUM_COL_W = COL_W + 2;
   localparam int SUM_ROW_W = ROW_W + 2;

   // default parameter values
   localparam int DEF_SCREEN_ROWS    = 23;
   localparam int DEF_SCREEN_COLUMNS = 80;
   localparam int DEF_TAB_SPACES     = 4;

   // register reset values
   localparam logic [COL_W-1:0] BOX_WIDTH_RESET  = 7'd80;
   localparam logic [ROW_W-1:0] BOX_HEIGHT_RESET = 5'd23;

   // cursor row saturation point
   localparam logic [ROW_W-1:0] ROW_MAX = 5'd31;

   // character codes
   localparam logic [CHAR_W-1:0] CH_NUL     = 8'd0;
   localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_COLUMN = 2'd0,
      CSR_ORIGIN_ROW    = 2'd1,
      CSR_BOX_WIDTH     = 2'd2,
      CSR_BOX_HEIGHT    = 2'd3
   } csr_index_type;

endpackage

FILE: rtl/wtcw_engine.sv
// Input register, cursor state and single-pass character handling.
`timescale 1ns / 1ps

module wtcw_engine #(
   parameter int SCREEN_ROWS    = wtcw_pkg::DEF_SCREEN_ROWS,
   parameter int SCREEN_COLUMNS = wtcw_pkg::DEF_SCREEN_COLUMNS,
   parameter int TAB_SPACES     = wtcw_pkg::DEF_TAB_SPACES,
   parameter int CNT_W          = $clog2(TAB_SPACES + 1)
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           req_valid,
   output logic                                           req_stall,
   input  logic                                           req_starts_string,
   input  logic [wtcw_pkg::CHAR_W-1:0]                    req_char_code,
   input  logic [wtcw_pkg::COL_W-1:0]                     origin_column,
   input  logic [wtcw_pkg::ROW_W-1:0]                     origin_row,
   input  logic [wtcw_pkg::COL_W-1:0]                     box_width,
   input  logic [wtcw_pkg::ROW_W-1:0]                     box_height,
   input  logic                                           buf_free,
   output logic                                           in_pending,
   output logic                                           ld_valid,
   output logic [CNT_W-1:0]                               ld_count,
   output logic [wtcw_pkg::ROW_W-1:0]                     ld_row,
   output logic [TAB_SPACES-1:0][wtcw_pkg::COL_W-1:0]     ld_col,
   output logic [wtcw_pkg::CHAR_W-1:0]                    ld_char
);
   import wtcw_pkg::*;

   logic                 in_valid_ff;
   logic                 in_start_ff;
   logic [CHAR_W-1:0]    in_char_ff;

   logic [COL_W-1:0]     cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]     cur_row_ff, cur_row_in;
   logic                 stopped_ff, stopped_in;

   logic [COL_W-1:0]     base_col;
   logic [ROW_W-1:0]     base_row;
   logic                 base_stop;
   logic [ROW_W-1:0]     row_inc;
   logic                 ignore_char, is_newline, is_tab;

   logic [SUM_COL_W-1:0] tab_col;
   logic [SUM_COL_W-1:0] tab_scol;
   logic                 tab_fit;
   logic [CNT_W-1:0]     tab_steps;
   logic [CNT_W-1:0]     tab_writes;
   logic [SUM_ROW_W-1:0] base_srow;

   logic                 wrap;
   logic [COL_W-1:0]     ord_col;
   logic [ROW_W-1:0]     ord_row;
   logic                 halt;
   logic [SUM_COL_W-1:0] ord_scol;
   logic [SUM_ROW_W-1:0] ord_srow;
   logic                 ord_write;

   logic [CNT_W-1:0]     count;
   logic                 advance;

   // hold the item until its writes can go to the output buffer
   assign advance    = in_valid_ff && ((count == '0) || buf_free);
   assign req_stall  = in_valid_ff && !advance;
   assign in_pending = in_valid_ff;
   assign ld_valid   = in_valid_ff && (count != '0) && buf_free;
   assign ld_count   = count;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_start_ff <= req_starts_string;
         in_char_ff  <= req_char_code;
      end
   end

   // cursor state, updated when the item leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff <= '0;
         cur_row_ff <= '0;
         stopped_ff <= 1'b0;
      end else if (advance) begin
         cur_col_ff <= cur_col_in;
         cur_row_ff <= cur_row_in;
         stopped_ff <= stopped_in;
      end
   end

   // apply a string start before anything else
   always_comb begin
      base_col    = in_start_ff ? '0 : cur_col_ff;
      base_row    = in_start_ff ? '0 : cur_row_ff;
      base_stop   = in_start_ff ? 1'b0 : stopped_ff;
      ignore_char = base_stop || (in_char_ff == CH_NUL);
      is_newline  = (in_char_ff == CH_NEWLINE);
      is_tab      = (in_char_ff == CH_TAB);
      row_inc     = (base_row != ROW_MAX) ? base_row + 1'b1 : base_row;
      base_srow   = SUM_ROW_W'(origin_row) + SUM_ROW_W'(base_row);
   end

   // tab: fitting steps form a prefix, and so do on-screen ones
   always_comb begin
      tab_steps  = '0;
      tab_writes = '0;
      tab_col    = '0;
      tab_scol   = '0;
      tab_fit    = 1'b0;
      for (int k = 0; k < TAB_SPACES; k++) begin
         tab_col  = SUM_COL_W'(base_col) + SUM_COL_W'(k);
         tab_scol = SUM_COL_W'(origin_column) + tab_col;
         tab_fit  = (tab_col + SUM_COL_W'(2)) < SUM_COL_W'(box_width);
         if (tab_fit) begin
            tab_steps = tab_steps + 1'b1;
         end
         if (tab_fit && (tab_scol < SUM_COL_W'(SCREEN_COLUMNS))
             && (base_srow < SUM_ROW_W'(SCREEN_ROWS))) begin
            tab_writes = tab_writes + 1'b1;
         end
         ld_col[k] = tab_scol[COL_W-1:0];
      end
      // ordinary characters use the first entry
      if (!is_tab) begin
         ld_col[0] = ord_scol[COL_W-1:0];
      end
   end

   // ordinary character: wrap, height check, screen check
   always_comb begin
      wrap      = (SUM_COL_W'(base_col) + 1'b1) >= SUM_COL_W'(box_width);
      ord_col   = wrap ? '0 : base_col;
      ord_row   = wrap ? row_inc : base_row;
      halt      = ord_row > box_height;
      ord_scol  = SUM_COL_W'(origin_column) + SUM_COL_W'(ord_col);
      ord_srow  = SUM_ROW_W'(origin_row) + SUM_ROW_W'(ord_row);
      ord_write = !halt && (ord_scol < SUM_COL_W'(SCREEN_COLUMNS))
                  && (ord_srow < SUM_ROW_W'(SCREEN_ROWS));
   end

   // select the result and the next cursor
   always_comb begin
      count      = '0;
      cur_col_in = base_col;
      cur_row_in = base_row;
      stopped_in = base_stop;
      ld_row     = ord_srow[ROW_W-1:0];
      ld_char    = in_char_ff;
      if (is_tab) begin
         ld_row  = base_srow[ROW_W-1:0];
         ld_char = CH_SPACE;
      end
      if (!ignore_char) begin
         if (is_newline) begin
            cur_col_in = '0;
            cur_row_in = row_inc;
         end else if (is_tab) begin
            count      = tab_writes;
            cur_col_in = base_col + COL_W'(tab_steps);
         end else if (halt) begin
            cur_col_in = ord_col;
            cur_row_in = ord_row;
            stopped_in = 1'b1;
         end else begin
            count      = ord_write ? CNT_W'(1) : '0;
            cur_col_in = ord_col + 1'b1;
            cur_row_in = ord_row;
         end
      end
   end

endmodule

FILE: rtl/wtcw_out_buf.sv
// Output buffer: holds one item's cell writes, sends one per cycle unless stalled.
`timescale 1ns / 1ps

module wtcw_out_buf #(
   parameter int TAB_SPACES = wtcw_pkg::DEF_TAB_SPACES,
   parameter int CNT_W      = $clog2(TAB_SPACES + 1),
   parameter int IDX_W      = (TAB_SPACES > 1) ? $clog2(TAB_SPACES) : 1
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       ld_valid,
   input  logic [CNT_W-1:0]                           ld_count,
   input  logic [wtcw_pkg::ROW_W-1:0]                 ld_row,
   input  logic [TAB_SPACES-1:0][wtcw_pkg::COL_W-1:0] ld_col,
   input  logic [wtcw_pkg::CHAR_W-1:0]                ld_char,
   output logic                                       buf_free,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic [wtcw_pkg::ROW_W-1:0]                 rsp_screen_row,
   output logic [wtcw_pkg::COL_W-1:0]                 rsp_screen_column,
   output logic [wtcw_pkg::CHAR_W-1:0]                rsp_cell_char,
   output logic                                       rsp_last_write
);
   import wtcw_pkg::*;

   logic                                bv_ff;
   logic [CNT_W-1:0]                    cnt_ff;
   logic [IDX_W-1:0]                    idx_ff;
   logic [ROW_W-1:0]                    row_ff;
   logic [CHAR_W-1:0]                   char_ff;
   logic [TAB_SPACES-1:0][COL_W-1:0]    col_ff;
   logic                                last;
   logic                                rsp_take;

   assign last     = (CNT_W'(idx_ff) + 1'b1) == cnt_ff;
   assign rsp_take = bv_ff && !rsp_stall;
   assign buf_free = !bv_ff || (rsp_take && last);

   assign rsp_valid         = bv_ff;
   assign rsp_screen_row    = row_ff;
   assign rsp_screen_column = col_ff[idx_ff];
   assign rsp_cell_char     = char_ff;
   assign rsp_last_write    = last;

   // control: load a new batch or step through the current one
   always_ff @(posedge clock) begin
      if (reset) begin
         bv_ff  <= 1'b0;
         idx_ff <= '0;
      end else if (ld_valid) begin
         bv_ff  <= 1'b1;
         idx_ff <= '0;
      end else if (rsp_take) begin
         if (last) begin
            bv_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (ld_valid) begin
         cnt_ff  <= ld_count;
         row_ff  <= ld_row;
         col_ff  <= ld_col;
         char_ff <= ld_char;
      end
   end

endmodule

FILE: rtl/wrapped_text_cell_writer_top.sv
// Top level of the wrapped text cell writer: configuration registers and datapath.
//
// Usage:
//   req_* carries one character per transaction (starts_string, char_code).
//   rsp_* carries one screen cell write per transaction; last_write marks
//   the final write caused by a character. Newlines, ignored characters and
//   off-screen cells produce no transaction.
//   csr_* writes the box origin and size; csr_ready is always high. Write
//   only while no character is in flight.
// Path: the writes of a character pass through the input register, then
//   the output buffer.
// Throughput: one character per cycle while each causes at most one write
//   and no response is stalled. A tab causes up to TAB_SPACES writes, sent
//   one per cycle unless stalled, from the single output buffer it holds.
// Reset: clears the cursor, the stopped flag and all valid flags, and loads
//   the registers with origin 0,0, width 80 and height 23.
// Stall: a stalled response holds its payload; the input register still
//   takes characters until it holds one with writes, then req_stall rises.
`timescale 1ns / 1ps

module wrapped_text_cell_writer_top #(
   parameter int SCREEN_ROWS    = wtcw_pkg::DEF_SCREEN_ROWS,
   parameter int SCREEN_COLUMNS = wtcw_pkg::DEF_SCREEN_COLUMNS,
   parameter int TAB_SPACES     = wtcw_pkg::DEF_TAB_SPACES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_starts_string,
   input  logic [wtcw_pkg::CHAR_W-1:0]     req_char_code,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [wtcw_pkg::ROW_W-1:0]      rsp_screen_row,
   output logic [wtcw_pkg::COL_W-1:0]      rsp_screen_column,
   output logic [wtcw_pkg::CHAR_W-1:0]     rsp_cell_char,
   output logic                            rsp_last_write,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [wtcw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wtcw_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import wtcw_pkg::*;

   localparam int CNT_W = $clog2(TAB_SPACES + 1);

   logic [COL_W-1:0]                 origin_col_ff;
   logic [ROW_W-1:0]                 origin_row_ff;
   logic [COL_W-1:0]                 box_width_ff;
   logic [ROW_W-1:0]                 box_height_ff;

   logic                             buf_free;
   logic                             in_pending;
   logic                             ld_valid;
   logic [CNT_W-1:0]                 ld_count;
   logic [ROW_W-1:0]                 ld_row;
   logic [TAB_SPACES-1:0][COL_W-1:0] ld_col;
   logic [CHAR_W-1:0]                ld_char;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_col_ff <= '0;
         origin_row_ff <= '0;
         box_width_ff  <= BOX_WIDTH_RESET;
         box_height_ff <= BOX_HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_ORIGIN_COLUMN: origin_col_ff <= csr_wdata[COL_W-1:0];
            CSR_ORIGIN_ROW:    origin_row_ff <= csr_wdata[ROW_W-1:0];
            CSR_BOX_WIDTH:     box_width_ff  <= csr_wdata[COL_W-1:0];
            CSR_BOX_HEIGHT:    box_height_ff <= csr_wdata[ROW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   wtcw_engine #(
      .SCREEN_ROWS    (SCREEN_ROWS),
      .SCREEN_COLUMNS (SCREEN_COLUMNS),
      .TAB_SPACES     (TAB_SPACES),
      .CNT_W          (CNT_W)
   ) u_engine (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_starts_string (req_starts_string),
      .req_char_code     (req_char_code),
      .origin_column     (origin_col_ff),
      .origin_row        (origin_row_ff),
      .box_width         (box_width_ff),
      .box_height        (box_height_ff),
      .buf_free          (buf_free),
      .in_pending        (in_pending),
      .ld_valid          (ld_valid),
      .ld_count          (ld_count),
      .ld_row            (ld_row),
      .ld_col            (ld_col),
      .ld_char           (ld_char)
   );

   wtcw_out_buf #(
      .TAB_SPACES (TAB_SPACES),
      .CNT_W      (CNT_W)
   ) u_out_buf (
      .clock             (clock),
      .reset             (reset),
      .ld_valid          (ld_valid),
      .ld_count          (ld_count),
      .ld_row            (ld_row),
      .ld_col            (ld_col),
      .ld_char           (ld_char),
      .buf_free          (buf_free),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_screen_row    (rsp_screen_row),
      .rsp_screen_column (rsp_screen_column),
      .rsp_cell_char     (rsp_cell_char),
      .rsp_last_write    (rsp_last_write)
   );

   // a batch loads only into a free buffer
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      ld_valid |-> buf_free)
      else $error("write batch loaded into a busy output buffer");

   // a batch is not cut short after a non-final write
   a_batch_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_write) |=> rsp_valid)
      else $error("write batch ended without a final write");

   // input backpressure only when a character is held
   a_stall_pending: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_pending)
      else $error("request stalled with an empty input register");

   // a batch is never loaded with no writes
   a_load_count: assert property (@(posedge clock) disable iff (reset)
      ld_valid |-> (ld_count != '0))
      else $error("empty write batch loaded");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the wrapped text cell writer: stimulus, prediction and checking.
`timescale 1ns / 1ps

module tb;
   import wtcw_pkg::*;

   localparam int SCREEN_ROWS    = DEF_SCREEN_ROWS;
   localparam int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS;
   localparam int TAB_SPACES     = DEF_TAB_SPACES;
   localparam int QUIET_LIMIT    = 2000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_CHARS    = 8;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_pattern_type;

   typedef struct {
      logic              starts;
      logic [CHAR_W-1:0] code;
      bit                drain_first;
   } char_item_type;

   typedef struct {
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [CHAR_W-1:0] ch;
      logic              last;
   } cell_write_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_starts_string = 1'b0;
   logic [CHAR_W-1:0]     req_char_code = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [ROW_W-1:0]      rsp_screen_row;
   logic [COL_W-1:0]      rsp_screen_column;
   logic [CHAR_W-1:0]     rsp_cell_char;
   logic                  rsp_last_write;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor copy of the box settings and the cursor
   logic [COL_W-1:0] origin_col_r  = '0;
   logic [ROW_W-1:0] origin_row_r  = '0;
   logic [COL_W-1:0] box_width_r   = BOX_WIDTH_RESET;
   logic [ROW_W-1:0] box_height_r  = BOX_HEIGHT_RESET;
   logic [COL_W-1:0] cur_col       = '0;
   logic [ROW_W-1:0] cur_row       = '0;
   logic             halted        = 1'b0;

   char_item_type  chars_to_send[$];
   cell_write_type writes_due[$];
   char_item_type  on_wire;

   int gap_pct       = 0;
   int stall_pct     = 0;
   int chars_pushed  = 0;
   int chars_taken   = 0;
   int writes_seen   = 0;
   int regs_written  = 0;
   int strings_made  = 0;
   int mismatches    = 0;
   int quiet         = 0;

   wrapped_text_cell_writer_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_starts_string (req_starts_string),
      .req_char_code     (req_char_code),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_screen_row    (rsp_screen_row),
      .rsp_screen_column (rsp_screen_column),
      .rsp_cell_char     (rsp_cell_char),
      .rsp_last_write    (rsp_last_write),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // queue one cell write if the cell lies on the screen
   function automatic void emit_cell(logic [CHAR_W-1:0] ch);
      int sc;
      int sr;
      sc = int'(origin_col_r) + int'(cur_col);
      sr = int'(origin_row_r) + int'(cur_row);
      if (sc < SCREEN_COLUMNS && sr < SCREEN_ROWS)
         writes_due.push_back('{ROW_W'(sr), COL_W'(sc), ch, 1'b0});
   endfunction

   // advance the cursor for one character and queue the cell writes it causes
   function automatic void place_character(char_item_type it);
      int lim;
      int first;
      lim   = int'(box_width_r);
      first = writes_due.size();
      if (it.starts) begin
         cur_col = '0;
         cur_row = '0;
         halted  = 1'b0;
      end
      if (halted || it.code == CH_NUL)
         return;
      if (it.code == CH_NEWLINE) begin
         cur_col = '0;
         if (cur_row != ROW_MAX)
            cur_row = cur_row + 1'b1;
      end else if (it.code == CH_TAB) begin
         for (int k = 0; k < TAB_SPACES; k++) begin
            if (int'(cur_col) < lim - 2) begin
               emit_cell(CH_SPACE);
               cur_col = cur_col + 1'b1;
            end
         end
      end else begin
         // wrap before the last column of the box
         if (int'(cur_col) >= lim - 1) begin
            cur_col = '0;
            if (cur_row != ROW_MAX)
               cur_row = cur_row + 1'b1;
         end
         if (cur_row > box_height_r) begin
            halted = 1'b1;
            return;
         end
         emit_cell(it.code);
         cur_col = cur_col + 1'b1;
      end
      if (writes_due.size() > first)
         writes_due[writes_due.size() - 1].last = 1'b1;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         mismatches++;
         $display("%0t: cell write %s mismatch, expected %0d, actual %0d",
                  $time, name, want, got);
      end
   endfunction

   function automatic void add_char(logic starts, logic [CHAR_W-1:0] code, bit drain = 1'b0);
      chars_to_send.push_back('{starts, code, drain});
      chars_pushed++;
   endfunction

   // character driver: present the next pending transaction, hold it while stalled
   always @(posedge clock) begin
      bit go;
      if (reset) begin
         req_valid         <= 1'b0;
         req_starts_string <= 1'b0;
         req_char_code     <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            place_character(on_wire);
            chars_taken++;
         end
         if (!req_valid || !req_stall) begin
            go = chars_to_send.size() != 0;
            if (go && chars_to_send[0].drain_first && writes_due.size() != 0)
               go = 1'b0;
            if (go && $urandom_range(99) < gap_pct)
               go = 1'b0;
            if (go) begin
               on_wire           = chars_to_send.pop_front();
               req_valid         <= 1'b1;
               req_starts_string <= on_wire.starts;
               req_char_code     <= on_wire.code;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // cell write monitor: compare each transaction with the oldest expected write
   always @(posedge clock) begin
      cell_write_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            writes_seen++;
            if (writes_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected cell write row %0d col %0d char %0d last %0d",
                        $time, rsp_screen_row, rsp_screen_column, rsp_cell_char,
                        rsp_last_write);
            end else begin
               want = writes_due.pop_front();
               check_field("screen_row", want.row, rsp_screen_row);
               check_field("screen_column", want.col, rsp_screen_column);
               check_field("cell_char", want.ch, rsp_cell_char);
               check_field("last_write", want.last, rsp_last_write);
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // watchdog: end the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d writes still expected",
                     $time, quiet, writes_due.size());
            $display("wrapped_text_cell_writer_top verification failed");
            $finish;
         end
      end
   end

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_ORIGIN_COLUMN: origin_col_r = COL_W'(data);
         CSR_ORIGIN_ROW:    origin_row_r = ROW_W'(data);
         CSR_BOX_WIDTH:     box_width_r  = COL_W'(data);
         CSR_BOX_HEIGHT:    box_height_r = ROW_W'(data);
         default: ;
      endcase
      regs_written++;
      csr_valid <= 1'b0;
   endtask

   task automatic set_box(int oc, int orow, int w, int h);
      write_reg(CSR_ORIGIN_COLUMN, CSR_DATA_W'(oc));
      write_reg(CSR_ORIGIN_ROW, CSR_DATA_W'(orow));
      write_reg(CSR_BOX_WIDTH, CSR_DATA_W'(w));
      write_reg(CSR_BOX_HEIGHT, CSR_DATA_W'(h));
   endtask

   task automatic set_idle(idle_pattern_type pat);
      case (pat)
         IDLE_SENDER:   begin gap_pct = 79; stall_pct = 0;  end
         IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 79; end
         IDLE_BOTH:     begin gap_pct = 37; stall_pct = 37; end
         default:       begin gap_pct = 0;  stall_pct = 0;  end
      endcase
   endtask

   // wait until every character is taken and every write has come, then let the pipe drain
   task automatic settle();
      while (chars_taken != chars_pushed || writes_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly well-formed strings with random content, some stray characters
   task automatic queue_random_text(int budget);
      int n;
      int len;
      int r;
      logic [CHAR_W-1:0] c;
      n = 0;
      while (n < budget) begin
         if ($urandom_range(99) < 80) begin
            strings_made++;
            len = ($urandom_range(3) == 0) ? $urandom_range(40, 12) : $urandom_range(10, 1);
            for (int i = 0; i < len; i++) begin
               r = $urandom_range(99);
               if (r < 12)
                  c = CH_NEWLINE;
               else if (r < 22)
                  c = CH_TAB;
               else if (r < 72)
                  c = CHAR_W'($urandom_range(126, 33));
               else
                  c = CHAR_W'($urandom_range(255, 1));
               add_char(i == 0, c, (i == 0) && (strings_made % 6 == 0));
            end
            n += len;
         end else begin
            add_char(1'($urandom_range(1)), CHAR_W'($urandom_range(255, 1)));
            n++;
         end
      end
   endtask

   initial begin
      int w;
      int h;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: extremes of the byte, character zero, tab, newline
      set_idle(IDLE_NONE);
      add_char(1'b1, 8'd65);
      add_char(1'b0, 8'd255);
      add_char(1'b0, 8'd1);
      add_char(1'b0, CH_NUL);
      add_char(1'b0, CH_TAB);
      add_char(1'b0, CH_NEWLINE);
      add_char(1'b0, 8'd66);
      settle();

      // box at the screen corner: off-screen drops, wrap, tab drop, stop, restart
      set_box(78, 22, 4, 1);
      add_char(1'b1, 8'd97);
      add_char(1'b0, 8'd98);
      add_char(1'b0, 8'd99);
      add_char(1'b0, 8'd100);
      add_char(1'b0, CH_TAB);
      add_char(1'b0, CH_NEWLINE);
      add_char(1'b0, 8'd101);
      add_char(1'b0, 8'd102);
      add_char(1'b1, 8'd103);
      add_char(1'b1, CH_TAB);
      settle();

      // width below two: every character wraps, tabs write nothing
      set_box(0, 0, 1, 23);
      add_char(1'b1, 8'd120);
      add_char(1'b0, 8'd121);
      add_char(1'b0, CH_TAB);
      add_char(1'b1, CH_NEWLINE);
      add_char(1'b0, 8'd122);
      settle();

      // random phases over box settings and idle patterns
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0) begin
            set_box(0, 0, 2, 0);
         end else if (p == 1) begin
            set_box(79, 22, 80, 23);
         end else begin
            w = ($urandom_range(1) == 0) ? $urandom_range(12, 2) : $urandom_range(80, 13);
            h = ($urandom_range(1) == 0) ? $urandom_range(4, 0) : $urandom_range(23, 5);
            set_box($urandom_range(79), $urandom_range(22), w, h);
         end
         set_idle(idle_pattern_type'(p % 4));
         // run the row cursor up to saturation once
         if (p == 6) begin
            add_char(1'b1, 8'd83);
            for (int i = 0; i < 33; i++)
               add_char(1'b0, CH_NEWLINE);
            add_char(1'b0, CH_TAB);
            add_char(1'b0, 8'd84);
            add_char(1'b1, 8'd85);
         end
         queue_random_text(PHASE_CHARS);
         settle();
      end

      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d characters in %0d strings, checked %0d cell writes,", chars_taken,
               strings_made, writes_seen);
      $display("made %0d register writes over %0d box settings and four idle patterns.",
               regs_written, RANDOM_PHASES + 3);
      if (mismatches == 0 && writes_due.size() == 0)
         $display("wrapped_text_cell_writer_top verification clean");
      else
         $display("wrapped_text_cell_writer_top verification failed");
      $finish;
   end

endmodule

FILE: sim.f
rtl/wtcw_pkg.sv
rtl/wtcw_engine.sv
rtl/wtcw_out_buf.sv
rtl/wrapped_text_cell_writer_top.sv
tb/tb.sv
